// File: hw/rtl/event_delay_queue_top_macros.svh
// ----------------------------------------------------------------------------
// event delay queue assertion macros
// concurrent check wrappers, empty when built for synthesis
// ----------------------------------------------------------------------------
`ifndef EVENT_DELAY_QUEUE_TOP_MACROS_SVH
`define EVENT_DELAY_QUEUE_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication on clk, off during reset
`define EDQ_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("edq assertion failed");
// next-cycle implication on clk, off during reset
`define EDQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("edq assertion failed");
`else
`define EDQ_ASSERT_IMPL(lbl, ante, cons)
`define EDQ_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: hw/rtl/edq_pkg.sv
// ----------------------------------------------------------------------------
// edq_pkg
// shared types, sizes and codes of the event delay queue
// ----------------------------------------------------------------------------
package edq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int TAG_BITS    = 16;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
	// absolute due time, compared modulo 2^KEY_W against the tick counter
	localparam int KEY_W       = 17;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(QUEUE_DEPTH);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DELAY_TICKS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_USE_ITEM_DELAY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPIKE_WEIGHT   = 2'd2;

	// request actions
	localparam logic ACT_ARRIVE = 1'b0;
	localparam logic ACT_TICK   = 1'b1;

	typedef struct packed {
		logic        action;
		logic [15:0] event_tag;
		logic [15:0] event_delay;
	} item_t;

	typedef struct packed {
		logic [15:0]        delivered_tag;
		logic signed [15:0] delivered_weight;
		logic               dropped;
		logic               last_of_run;
	} result_t;

	typedef struct packed {
		logic [KEY_W-1:0]    key;
		logic [TAG_BITS-1:0] tag;
	} entry_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] addr;
		entry_t           data;
	} mem_wr_t;

	// circular buffer index: base plus offset, wrapped at the depth
	function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W-1:0] base,
			input logic [IDX_W-1:0] ofs);
		logic [IDX_W:0] sum;
		sum = {1'b0, base} + {1'b0, ofs};
		if (sum >= (IDX_W + 1)'(QUEUE_DEPTH)) begin
			sum = sum - (IDX_W + 1)'(QUEUE_DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

endpackage

// File: hw/rtl/edq_store.sv
// ----------------------------------------------------------------------------
// edq_store
// entry memory of the queue: one write port, one registered read port
// ----------------------------------------------------------------------------
module edq_store (
	input  logic                    clk,
	input  edq_pkg::mem_wr_t        wr,
	input  logic [edq_pkg::IDX_W-1:0] raddr,
	output edq_pkg::entry_t         rdata
);
	import edq_pkg::*;

	entry_t mem_q [QUEUE_DEPTH];
	entry_t rdata_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem_q[wr.addr] <= wr.data;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/edq_alu.sv
// ----------------------------------------------------------------------------
// edq_alu
// shared subtract and compare: remaining count of an entry against a bound
// ----------------------------------------------------------------------------
module edq_alu (
	input  logic [edq_pkg::KEY_W-1:0]        key,
	input  logic [edq_pkg::KEY_W-1:0]        now,
	input  logic signed [edq_pkg::KEY_W-1:0] thr,
	output logic                             le
);
	import edq_pkg::*;

	logic signed [KEY_W-1:0] rem;

	// remaining ticks of the entry, then signed compare
	assign rem = key - now;
	assign le  = (rem <= thr);

endmodule

// File: hw/rtl/event_delay_queue_top.sv
// ----------------------------------------------------------------------------
// event_delay_queue_top
// sorted timed event delay queue with an entry memory of one write and one read port, a shared
// compare unit and a small sequencer
// ----------------------------------------------------------------------------
// channel   | ports                          | handshake
// request   | start, busy, item              | taken when start & !busy
// result    | result_valid, result           | one-cycle strobe, no backpressure
// config    | cfg_we, cfg_index, cfg_data    | written when cfg_we is high
//
// tick: S_TRD and S_TCHK for each released entry and for the entry that stops
// the scan; arrival: S_ARD and S_ACHK for each entry shifted toward the tail,
// then S_ARD and S_ACHK, or S_ARD alone when the new entry lands at the head;
// a refusal on a full queue keeps busy low and its result follows in the
// next cycle; scans are paced by the one read port and its registered data
// reset clears occupancy, head and the tick counter; memory contents are
// undefined until written and there is no clearing pass
// results cannot be stalled; the last one of a tick leaves as busy falls
// ----------------------------------------------------------------------------
`include "event_delay_queue_top_macros.svh"

module event_delay_queue_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  edq_pkg::item_t                  item,
	output logic                            result_valid,
	output edq_pkg::result_t                result,
	input  logic                            cfg_we,
	input  logic [edq_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [edq_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import edq_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_TRD  = 5'b00010,
		S_TCHK = 5'b00100,
		S_ARD  = 5'b01000,
		S_ACHK = 5'b10000
	} state_t;

	state_t                  state_q;
	logic [15:0]             delay_ticks_q;
	logic                    use_item_delay_q;
	logic signed [15:0]      spike_weight_q;
	logic [IDX_W-1:0]        head_q;
	logic [OCC_W-1:0]        occ_q;
	logic [KEY_W-1:0]        now_q;
	logic [IDX_W-1:0]        pos_q;
	entry_t                  new_q;
	logic signed [KEY_W-1:0] cnt_q;
	logic                    pend_q;
	logic [TAG_BITS-1:0]     pend_tag_q;
	logic                    res_valid_q;
	result_t                 res_q;

	logic                    accept;
	logic                    drop_req;
	logic [15:0]             d_item;
	logic [15:0]             d_sel;
	logic [KEY_W-1:0]        cnt_new;
	logic [IDX_W-1:0]        raddr;
	entry_t                  rdata;
	mem_wr_t                 wr;
	logic signed [KEY_W-1:0] thr;
	logic                    le;
	logic                    due;

	assign busy     = (state_q != S_IDLE);
	assign accept   = start && !busy;
	// arrival refused on a full queue
	assign drop_req = accept && (item.action == ACT_ARRIVE) && (occ_q == OCC_FULL);

	// delay of the arriving event, stored as delay minus one
	assign d_item  = (item.event_delay == 16'd0) ? 16'd1 : item.event_delay;
	assign d_sel   = use_item_delay_q ? d_item : delay_ticks_q;
	assign cnt_new = {1'b0, d_sel} - KEY_W'(1);

	// read address of the scan
	always_comb begin
		case (state_q)
			S_ARD:   raddr = wrap_idx(head_q, pos_q - IDX_W'(1));
			default: raddr = head_q;
		endcase
	end

	// memory write: insert the new entry or shift one toward the tail
	always_comb begin
		wr = '0;
		case (state_q)
			S_ARD: begin
				if (pos_q == '0) begin
					wr.we   = 1'b1;
					wr.addr = head_q;
					wr.data = new_q;
				end
			end
			S_ACHK: begin
				wr.we   = 1'b1;
				wr.addr = wrap_idx(head_q, pos_q);
				wr.data = le ? new_q : rdata;
			end
			default: begin
				wr = '0;
			end
		endcase
	end

	edq_store u_store (
		.clk   (clk),
		.wr    (wr),
		.raddr (raddr),
		.rdata (rdata)
	);

	// bound is zero on a tick, the new count on an arrival
	assign thr = (state_q == S_ACHK) ? cnt_q : '0;

	edq_alu u_alu (
		.key (rdata.key),
		.now (now_q),
		.thr (thr),
		.le  (le)
	);

	assign due = (occ_q != '0) && le;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_ticks_q    <= '0;
			use_item_delay_q <= 1'b0;
			spike_weight_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DELAY_TICKS:    delay_ticks_q    <= cfg_data;
				REG_USE_ITEM_DELAY: use_item_delay_q <= cfg_data[0];
				REG_SPIKE_WEIGHT:   spike_weight_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			occ_q       <= '0;
			now_q       <= '0;
			pos_q       <= '0;
			pend_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (item.action == ACT_TICK) begin
							now_q   <= now_q + KEY_W'(1);
							state_q <= S_TRD;
						end else if (occ_q == OCC_FULL) begin
							res_valid_q <= 1'b1;
						end else begin
							pos_q   <= occ_q[IDX_W-1:0];
							state_q <= S_ARD;
						end
					end
				end
				S_TRD: begin
					state_q <= S_TCHK;
				end
				S_TCHK: begin
					if (due) begin
						if (pend_q) begin
							res_valid_q <= 1'b1;
						end
						pend_q  <= 1'b1;
						head_q  <= wrap_idx(head_q, IDX_W'(1));
						occ_q   <= occ_q - OCC_W'(1);
						state_q <= S_TRD;
					end else begin
						if (pend_q) begin
							res_valid_q <= 1'b1;
						end
						pend_q  <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				S_ARD: begin
					if (pos_q == '0) begin
						occ_q   <= occ_q + OCC_W'(1);
						state_q <= S_IDLE;
					end else begin
						state_q <= S_ACHK;
					end
				end
				S_ACHK: begin
					if (le) begin
						occ_q   <= occ_q + OCC_W'(1);
						state_q <= S_IDLE;
					end else begin
						pos_q   <= pos_q - IDX_W'(1);
						state_q <= S_ARD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload of the scan and of the results
	always_ff @(posedge clk) begin
		if (accept) begin
			new_q.key <= now_q + cnt_new;
			new_q.tag <= item.event_tag[TAG_BITS-1:0];
			cnt_q     <= cnt_new;
		end
		if (drop_req) begin
			res_q.delivered_tag    <= 16'(item.event_tag[TAG_BITS-1:0]);
			res_q.delivered_weight <= '0;
			res_q.dropped          <= 1'b1;
			res_q.last_of_run      <= 1'b1;
		end
		if (state_q == S_TCHK && pend_q) begin
			res_q.delivered_tag    <= 16'(pend_tag_q);
			res_q.delivered_weight <= spike_weight_q;
			res_q.dropped          <= 1'b0;
			res_q.last_of_run      <= !due;
		end
		if (state_q == S_TCHK && due) begin
			pend_tag_q <= rdata.tag;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// checks
	`EDQ_ASSERT_IMPL(a_occ_bound, 1'b1, occ_q <= OCC_FULL)
	`EDQ_ASSERT_NEXT(a_full_drops, drop_req, res_valid_q && res_q.dropped && res_q.last_of_run)
	`EDQ_ASSERT_IMPL(a_pend_in_tick, pend_q, state_q == S_TRD || state_q == S_TCHK)
	`EDQ_ASSERT_NEXT(a_release_pops, state_q == S_TCHK && due, occ_q == $past(occ_q) - OCC_W'(1))
	`EDQ_ASSERT_IMPL(a_drop_idle, res_valid_q && res_q.dropped, state_q == S_IDLE)

endmodule

// File: bench/tb_event_delay_queue_top.sv
// ----------------------------------------------------------------------------
// tb_event_delay_queue_top
// drives arrivals and ticks into the event delay queue, keeps a sorted copy
// of the pending events to predict every release and refusal, and compares
// each result strobe field by field; ends by queueing the widest delays
// and issuing LONG_TICKS ticks after queueing them
// ----------------------------------------------------------------------------
module tb_event_delay_queue_top;
	timeunit 1ns;
	timeprecision 1ps;

	import edq_pkg::*;

	// idle time before a register write, covers a full shift or scan
	localparam int SETTLE_CYCLES = 2 * QUEUE_DEPTH + 8;
	// cycles with no request or result taken before the run is abandoned
	localparam int STALL_LIMIT   = 4000;
	// ticks issued after the widest delays are queued
	localparam int LONG_TICKS    = 4;
	// index past the last register, writes there are ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	// pending events in release order and the results they will produce
	class delay_queue_scoreboard;
		typedef struct {
			int          count;
			logic [15:0] tag;
		} slot_t;

		slot_t       slots[$];
		result_t     due[$];
		logic [15:0] fixed_delay;
		logic        item_delay_mode;
		logic [15:0] weight;
		int          errors;

		function new();
			fixed_delay     = '0;
			item_delay_mode = 1'b0;
			weight          = '0;
			errors          = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_DELAY_TICKS: begin
					fixed_delay = data;
				end
				REG_USE_ITEM_DELAY: begin
					item_delay_mode = data[0];
				end
				REG_SPIKE_WEIGHT: begin
					weight = data;
				end
				default: begin
				end
			endcase
		endfunction

		function void note_request(item_t it);
			int      cnt;
			int      pos;
			slot_t   s;
			result_t r;
			if (it.action == ACT_ARRIVE) begin
				// full queue refuses the arrival
				if (slots.size() >= QUEUE_DEPTH) begin
					r.delivered_tag    = it.event_tag;
					r.delivered_weight = '0;
					r.dropped          = 1'b1;
					r.last_of_run      = 1'b1;
					due.insert(due.size(), r);
				end else begin
					// variable delay of zero counts as one
					if (item_delay_mode) begin
						cnt = (it.event_delay == 16'd0) ? 0 : int'(it.event_delay) - 1;
					end else begin
						cnt = int'(fixed_delay) - 1;
					end
					// behind every entry with count <= own, ties keep arrival order
					pos = 0;
					while (pos < slots.size() && slots[pos].count <= cnt) begin
						pos++;
					end
					s.count = cnt;
					s.tag   = it.event_tag;
					slots.insert(pos, s);
				end
			end else begin
				// one tick: age everything, then release from the head
				foreach (slots[i]) begin
					slots[i].count--;
				end
				while (slots.size() > 0 && slots[0].count <= 0) begin
					r.delivered_tag    = slots[0].tag;
					r.delivered_weight = weight;
					r.dropped          = 1'b0;
					r.last_of_run      = (slots.size() == 1) || (slots[1].count > 0);
					due.insert(due.size(), r);
					slots.delete(0);
				end
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (due.size() == 0) begin
				$error("unexpected result: tag %h weight %0d dropped %b last %b",
					got.delivered_tag, got.delivered_weight, got.dropped, got.last_of_run);
				errors++;
				return;
			end
			want = due[0];
			due.delete(0);
			if (got.delivered_tag !== want.delivered_tag) begin
				$error("delivered_tag: expected %h, got %h", want.delivered_tag,
					got.delivered_tag);
				errors++;
			end
			if (got.delivered_weight !== want.delivered_weight) begin
				$error("delivered_weight: expected %0d, got %0d", want.delivered_weight,
					got.delivered_weight);
				errors++;
			end
			if (got.dropped !== want.dropped) begin
				$error("dropped: expected %b, got %b", want.dropped, got.dropped);
				errors++;
			end
			if (got.last_of_run !== want.last_of_run) begin
				$error("last_of_run: expected %b, got %b", want.last_of_run, got.last_of_run);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	item_t                 item;
	logic                  result_valid;
	result_t               result;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	delay_queue_scoreboard sb;
	int                    quiet_cycles = 0;
	int                    idle_pct = 0;

	event_delay_queue_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// 2 ns clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// register writes, taken requests and result strobes, all at the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				sb.write_reg(cfg_index, cfg_data);
			end
			if (start && !busy) begin
				sb.note_request(item);
			end
			if (result_valid) begin
				sb.check_result(result);
			end
			quiet_cycles <= ((start && !busy) || result_valid) ? 0 : quiet_cycles + 1;
		end
	end

	// watchdog on stalled traffic
	initial begin
		wait (quiet_cycles >= STALL_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

	function automatic item_t arrival(logic [15:0] delay);
		item_t it;
		it.action      = ACT_ARRIVE;
		it.event_tag   = 16'($urandom);
		it.event_delay = delay;
		return it;
	endfunction

	function automatic item_t tick_request();
		item_t it;
		it.action      = ACT_TICK;
		it.event_tag   = 16'($urandom);
		it.event_delay = 16'($urandom);
		return it;
	endfunction

	// hold the request until the block takes it
	task automatic send_request(input item_t it);
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy);
	endtask

	// request with random sender gaps and an occasional wait for all results
	task automatic issue(input item_t it);
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end else if ($urandom_range(0, 99) < 3) begin
			start <= 1'b0;
			do @(posedge clk); while (sb.due.size() != 0);
		end
		send_request(it);
	endtask

	// wait for every result, then let the block go idle
	task automatic drain();
		start <= 1'b0;
		while (sb.due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int    n_arrive;
		int    n_tick;
		int    issued;
		item_t it;

		start     = 1'b0;
		item      = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		arst_n    = 1'b0;
		sb        = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: fixed delay of zero releases on the next tick
		it = arrival(16'($urandom));
		it.event_tag = 16'h0000;
		send_request(it);
		send_request(tick_request());

		// fixed delay of two, tie keeps arrival order, a tick with nothing due
		drain();
		program_reg(REG_DELAY_TICKS, 16'd2);
		program_reg(REG_SPIKE_WEIGHT, 16'h0100);
		program_reg(REG_SPARE, 16'hFFFF);
		it = arrival(16'($urandom));
		it.event_tag = 16'hFFFF;
		send_request(it);
		send_request(arrival(16'($urandom)));
		send_request(tick_request());
		send_request(tick_request());

		// variable delays, fill the queue, refuse one, release in two ticks, third tick idle
		drain();
		program_reg(REG_USE_ITEM_DELAY, 16'hFFFF);
		program_reg(REG_SPIKE_WEIGHT, 16'h8000);
		send_request(arrival(16'd0));
		send_request(arrival(16'd3));
		send_request(arrival(16'd1));
		send_request(arrival(16'd2));
		for (int i = 0; i < QUEUE_DEPTH - 3; i++) begin
			send_request(arrival(16'd1));
		end
		repeat (3) send_request(tick_request());

		// random bursts of arrivals followed by ticks, several settings
		for (int phase = 0; phase < 6; phase++) begin
			drain();
			idle_pct = (phase < 2) ? 18 : (phase < 4) ? 45 : 0;
			case (phase)
				0: begin
					program_reg(REG_DELAY_TICKS, 16'd1);
					program_reg(REG_USE_ITEM_DELAY, {15'($urandom_range(0, 32767)), 1'b0});
					program_reg(REG_SPIKE_WEIGHT, 16'h7FFF);
				end
				1, 3, 5: begin
					program_reg(REG_USE_ITEM_DELAY, {15'($urandom_range(0, 32767)), 1'b1});
					program_reg(REG_SPIKE_WEIGHT, 16'($urandom));
				end
				2: begin
					program_reg(REG_DELAY_TICKS, 16'd0);
					program_reg(REG_USE_ITEM_DELAY, {15'($urandom_range(0, 32767)), 1'b0});
					program_reg(REG_SPARE, 16'($urandom));
				end
				default: begin
					program_reg(REG_DELAY_TICKS, 16'($urandom_range(3, 6)));
					program_reg(REG_USE_ITEM_DELAY, {15'($urandom_range(0, 32767)), 1'b0});
				end
			endcase
			issued = 0;
			while (issued < 64) begin
				n_arrive = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18)
					: $urandom_range(0, 5);
				n_tick   = $urandom_range(1, 6);
				for (int i = 0; i < n_arrive; i++) begin
					if (sb.item_delay_mode) begin
						issue(arrival(16'(($urandom_range(0, 7) == 0) ? $urandom_range(7, 24)
							: $urandom_range(0, 6))));
					end else begin
						issue(arrival(16'($urandom)));
					end
				end
				for (int i = 0; i < n_tick; i++) begin
					issue(tick_request());
				end
				issued += n_arrive + n_tick;
			end
		end

		// widest fixed and variable delays queued, then LONG_TICKS ticks
		drain();
		idle_pct = 0;
		program_reg(REG_DELAY_TICKS, 16'hFFFF);
		program_reg(REG_USE_ITEM_DELAY, 16'h0000);
		program_reg(REG_SPIKE_WEIGHT, 16'($urandom));
		send_request(arrival(16'($urandom)));
		drain();
		program_reg(REG_USE_ITEM_DELAY, 16'h0001);
		send_request(arrival(16'hFFFF));
		send_request(arrival(16'hFFFE));
		send_request(arrival(16'h0000));
		for (int i = 0; i < LONG_TICKS; i++) begin
			send_request(tick_request());
		end

		drain();
		if (sb.errors == 0 && sb.due.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
